/* hw/rtl/trt_pkg.sv */
// Shared types, constants and command/status structs of the trigger region table.
package trt_pkg;

  localparam int ENTRIES    = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int SIZE_SHIFT = 11;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 5;
  localparam int GROUP_W  = 16;
  localparam int SECTOR_W = 8;
  localparam int FLAG_W   = 7;
  localparam int UNITS_W  = 8;
  localparam int LOW_W    = 24;
  localparam int HIGH_W   = 25;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 64;

  // class mask bits hit by narrow (0x20) and wide (0x60) regions
  localparam int CLASS_NARROW_BIT = 5;
  localparam int CLASS_WIDE_BIT   = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FREE = 3'd0,
    OP_ADD_AT   = 3'd1,
    OP_CANCEL   = 3'd2,
    OP_FIND     = 3'd3,
    OP_READ     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  typedef enum logic [2:0] {
    RK_ADDR = 3'd0,
    RK_SLOT = 3'd1,
    RK_Q    = 3'd2,
    RK_FULL = 3'd3,
    RK_NONE = 3'd4,
    RK_DONE = 3'd5,
    RK_READ = 3'd6
  } res_kind_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [HIGH_W-1:0]   hy;
    logic [HIGH_W-1:0]   hx;
    logic [LOW_W-1:0]    ly;
    logic [LOW_W-1:0]    lx;
    logic                wide;
    logic [SECTOR_W-1:0] sector;
    logic [GROUP_W-1:0]  group;
  } entry_t;

  typedef struct packed {
    logic      load;
    logic      addr_clr;
    logic      addr_adv;
    logic      issue;
    logic      rd_sel_slot;
    logic      eval_en;
    logic      wr_en;
    logic      wr_at_addr;
    logic      clr_all;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_find;
    logic slot_ok;
    logic addr_last;
    logic addr_free;
    logic find_hit;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/trt_datapath.sv */
// Datapath of the trigger region table: command capture, entry memory, scan and result registers.
module trt_datapath
  import trt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [OP_W-1:0]     op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [GROUP_W-1:0]  group_r;
  logic [SECTOR_W-1:0] sector_r;
  logic [FLAG_W-1:0]   flags_r;
  logic [UNITS_W-1:0]  width_r;
  logic [UNITS_W-1:0]  height_r;
  logic [LOW_W-1:0]    xa_r;
  logic [LOW_W-1:0]    ya_r;
  logic [HIGH_W-1:0]   xb_r;
  logic [HIGH_W-1:0]   yb_r;
  logic [HANDLE_W-1:0] handle_r;

  entry_t              mem_r [ENTRIES];
  entry_t              rd_q_r;
  logic [IDX_W-1:0]    q_idx_r;
  logic                q_vld_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [IDX_W-1:0]    addr_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic [GROUP_W-1:0]  res_group_r;
  logic [SECTOR_W-1:0] res_sector_r;
  logic                out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [STATUS_W-1:0] res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_nxt;
  logic [HANDLE_W-1:0] res_handle_nxt;
  logic [GROUP_W-1:0]  res_group_nxt;
  logic [SECTOR_W-1:0] res_sector_nxt;

  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             q_valid;
  logic             class_hit;
  logic             box_hit;
  logic             find_hit;
  logic             cancel_hit;

  assign slot_idx = IDX_W'(slot_r);
  assign rd_addr  = cmd.rd_sel_slot ? slot_idx : addr_r;
  assign wr_addr  = cmd.wr_at_addr ? addr_r : slot_idx;

  always_comb begin
    wr_data        = '0;
    wr_data.group  = group_r;
    wr_data.sector = sector_r;
    wr_data.wide   = |flags_r;
    wr_data.lx     = xa_r;
    wr_data.ly     = ya_r;
    wr_data.hx     = {xa_r[LOW_W-1], xa_r} + (HIGH_W'(width_r) << SIZE_SHIFT);
    wr_data.hy     = {ya_r[LOW_W-1], ya_r} + (HIGH_W'(height_r) << SIZE_SHIFT);
    wr_data.handle = handle_r;
  end

  assign q_valid   = valid_r[q_idx_r];
  assign class_hit = flags_r[CLASS_NARROW_BIT] | (rd_q_r.wide & flags_r[CLASS_WIDE_BIT]);
  assign box_hit   = ($signed({rd_q_r.lx[LOW_W-1], rd_q_r.lx}) < $signed(xb_r)) &&
                     ($signed(rd_q_r.hx) > $signed({xa_r[LOW_W-1], xa_r})) &&
                     ($signed({rd_q_r.ly[LOW_W-1], rd_q_r.ly}) < $signed(yb_r)) &&
                     ($signed(rd_q_r.hy) > $signed({ya_r[LOW_W-1], ya_r}));
  assign find_hit   = q_vld_r && q_valid && class_hit && box_hit;
  assign cancel_hit = q_vld_r && q_valid && (rd_q_r.group == group_r) &&
                      (sector_r[SECTOR_W-1] || (rd_q_r.sector == sector_r));

  always_comb begin
    stat           = '0;
    stat.is_find   = (op_r == OP_FIND);
    stat.slot_ok   = int'(slot_r) < ENTRIES;
    stat.addr_last = (addr_r == IDX_W'(ENTRIES - 1));
    stat.addr_free = !valid_r[addr_r];
    stat.find_hit  = find_hit;
    stat.out_free  = !out_vld_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tuser;
      slot_r   <= in_tdata[4:0];
      group_r  <= in_tdata[20:5];
      sector_r <= in_tdata[28:21];
      flags_r  <= in_tdata[35:29];
      width_r  <= in_tdata[43:36];
      height_r <= in_tdata[51:44];
      xa_r     <= in_tdata[75:52];
      ya_r     <= in_tdata[99:76];
      xb_r     <= in_tdata[124:100];
      yb_r     <= in_tdata[149:125];
      handle_r <= in_tdata[181:150];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r  <= mem_r[rd_addr];
    q_idx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
      addr_r  <= '0;
      valid_r <= '0;
    end else begin
      q_vld_r <= cmd.issue;
      if (cmd.addr_clr) begin
        addr_r <= '0;
      end else if (cmd.addr_adv) begin
        addr_r <= addr_r + 1'b1;
      end
      if (cmd.clr_all) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (cmd.eval_en && (op_r == OP_CANCEL) && cancel_hit) begin
        valid_r[q_idx_r] <= 1'b0;
      end
    end
  end

  always_comb begin
    res_status_nxt = ST_OK;
    res_slot_nxt   = '0;
    res_handle_nxt = '0;
    res_group_nxt  = '0;
    res_sector_nxt = '0;
    case (cmd.res_kind)
      RK_ADDR: res_slot_nxt = SLOT_W'(addr_r);
      RK_SLOT: res_slot_nxt = slot_r;
      RK_Q:    res_slot_nxt = SLOT_W'(q_idx_r);
      RK_FULL: res_status_nxt = ST_FULL;
      RK_NONE: res_status_nxt = ST_NONE;
      RK_DONE: res_status_nxt = ST_OK;
      RK_READ: begin
        if (stat.slot_ok && q_valid) begin
          res_handle_nxt = rd_q_r.handle;
          res_group_nxt  = rd_q_r.group;
          res_sector_nxt = rd_q_r.sector;
        end else begin
          res_status_nxt = ST_NONE;
        end
      end
      default: res_status_nxt = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_handle_r <= res_handle_nxt;
      res_group_r  <= res_group_nxt;
      res_sector_r <= res_sector_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {1'b0, res_sector_r, res_group_r, res_handle_r, res_slot_r, res_status_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_all |=> (valid_r == '0))
    else $error("valid marks not cleared");

  a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |=> valid_r[$past(wr_addr)])
    else $error("written entry not marked valid");

endmodule

/* hw/rtl/trt_ctrl.sv */
// Controller state machine of the trigger region table.
module trt_ctrl
  import trt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [OP_W-1:0] in_tuser,
  input  dp_stat_t        stat,
  output ctl_cmd_t        cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FREE  = 8'b0000_0010,
    S_PUT   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_RDONE = 8'b0100_0000,
    S_POST  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_kind = RK_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load     = 1'b1;
          cmd.addr_clr = 1'b1;
          case (in_tuser)
            OP_ADD_FREE: state_nxt = S_FREE;
            OP_ADD_AT:   state_nxt = S_PUT;
            OP_CANCEL:   state_nxt = S_SCAN;
            OP_FIND:     state_nxt = S_SCAN;
            OP_READ:     state_nxt = S_READ;
            OP_CLEAR: begin
              cmd.clr_all  = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_DONE;
              state_nxt    = S_POST;
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_NONE;
              state_nxt    = S_POST;
            end
          endcase
        end
      end
      S_FREE: begin
        if (stat.addr_free) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_at_addr = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_kind   = RK_ADDR;
          state_nxt      = S_POST;
        end else if (stat.addr_last) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_FULL;
          state_nxt    = S_POST;
        end else begin
          cmd.addr_adv = 1'b1;
        end
      end
      S_PUT: begin
        cmd.res_load = 1'b1;
        if (stat.slot_ok) begin
          cmd.wr_en    = 1'b1;
          cmd.res_kind = RK_SLOT;
        end else begin
          cmd.res_kind = RK_NONE;
        end
        state_nxt = S_POST;
      end
      S_SCAN: begin
        cmd.issue    = 1'b1;
        cmd.addr_adv = 1'b1;
        cmd.eval_en  = 1'b1;
        if (stat.is_find && stat.find_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RK_Q;
          state_nxt    = S_POST;
        end else if (stat.addr_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.eval_en  = 1'b1;
        cmd.res_load = 1'b1;
        if (!stat.is_find) begin
          cmd.res_kind = RK_DONE;
        end else if (stat.find_hit) begin
          cmd.res_kind = RK_Q;
        end else begin
          cmd.res_kind = RK_NONE;
        end
        state_nxt = S_POST;
      end
      S_READ: begin
        cmd.issue       = 1'b1;
        cmd.rd_sel_slot = 1'b1;
        state_nxt       = S_RDONE;
      end
      S_RDONE: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_READ;
        state_nxt    = S_POST;
      end
      S_POST: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction taken while busy");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over pending output");

endmodule

/* hw/rtl/trigger_region_table.sv */
// Top level of the trigger region table.
// Use: one command transaction in on in_*, exactly one result transaction out on out_*.
// in_tuser carries the opcode: add into first free slot, add at slot, cancel group,
// find overlapping region, read slot, clear all. Unused opcodes answer "no match".
// The table holds 32 entries in a memory with registered read; valid marks sit in flops.
// Add at slot writes the entry and loads the result register; read issues a memory read first.
// Every result then moves from the result register into the output register.
// Add into first free slot walks the valid marks one slot a cycle.
// Cancel walks every slot through the memory read port.
// Find walks slots until the first hit or the last slot.
// Commands: one at a time; in_tready rises again in the cycle the result
// reaches the output register.
// Reset: clears all valid marks and the controller; no clearing pass is needed.
// Receiver stall: the output register holds one result; the next command is taken and
// worked, and its result waits until out_tready frees the register.
module trigger_region_table
  import trt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot, group, sector, flag_bits, width_units, height_units, x_a, y_a, x_b, y_b,
  // script_handle, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, result_slot, result_handle, result_group, result_sector, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  trt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  trt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* verif/tb_trigger_region_table.sv */
// Self-checking testbench of trigger_region_table: predicted results compared against out_* transactions.
module tb_trigger_region_table;
  timeunit 1ns;
  timeprecision 1ps;

  import trt_pkg::*;

  localparam logic [FLAG_W-1:0] CLASS_NARROW = 7'h20;
  localparam logic [FLAG_W-1:0] CLASS_WIDE   = 7'h60;
  localparam logic [OP_W-1:0]   OP_SPARE_6   = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_7   = 3'd7;

  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic [SLOT_W-1:0]          slot;
    logic signed [GROUP_W-1:0]  group;
    logic signed [SECTOR_W-1:0] sector;
    logic [FLAG_W-1:0]          flags;
    logic [UNITS_W-1:0]         w_units;
    logic [UNITS_W-1:0]         h_units;
    logic signed [LOW_W-1:0]    x_lo;
    logic signed [LOW_W-1:0]    y_lo;
    logic signed [HIGH_W-1:0]   x_hi;
    logic signed [HIGH_W-1:0]   y_hi;
    logic [HANDLE_W-1:0]        handle;
  } region_cmd_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [GROUP_W-1:0]  group;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } region_res_t;

  class region_scoreboard;
    bit                         live [ENTRIES];
    logic signed [GROUP_W-1:0]  grp  [ENTRIES];
    logic signed [SECTOR_W-1:0] sec  [ENTRIES];
    bit                         wide [ENTRIES];
    logic signed [LOW_W-1:0]    lo_x [ENTRIES];
    logic signed [LOW_W-1:0]    lo_y [ENTRIES];
    logic signed [HIGH_W-1:0]   hi_x [ENTRIES];
    logic signed [HIGH_W-1:0]   hi_y [ENTRIES];
    logic [HANDLE_W-1:0]        hdl  [ENTRIES];
    region_res_t                pending[$];
    int                         errors;

    function new();
      errors = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function void write_slot(int s, region_cmd_t c);
      live[s] = 1'b1;
      grp[s]  = c.group;
      sec[s]  = c.sector;
      wide[s] = (c.flags != '0);
      lo_x[s] = c.x_lo;
      lo_y[s] = c.y_lo;
      hi_x[s] = {c.x_lo[LOW_W-1], c.x_lo} + (HIGH_W'(c.w_units) << SIZE_SHIFT);
      hi_y[s] = {c.y_lo[LOW_W-1], c.y_lo} + (HIGH_W'(c.h_units) << SIZE_SHIFT);
      hdl[s]  = c.handle;
    endfunction

    function void note_command(region_cmd_t c);
      region_res_t       r;
      logic [FLAG_W-1:0] cls;
      int                i;
      r = '0;
      r.status = ST_NONE;
      case (c.op)
        OP_ADD_FREE: begin
          r.status = ST_FULL;
          for (i = 0; i < ENTRIES; i++) begin
            if (!live[i]) begin
              write_slot(i, c);
              r.status = ST_OK;
              r.slot = SLOT_W'(i);
              break;
            end
          end
        end
        OP_ADD_AT: begin
          write_slot(c.slot, c);
          r.status = ST_OK;
          r.slot = c.slot;
        end
        OP_CANCEL: begin
          for (i = 0; i < ENTRIES; i++) begin
            if (live[i] && grp[i] == c.group && (c.sector < 0 || sec[i] == c.sector))
              live[i] = 1'b0;
          end
          r.status = ST_OK;
        end
        OP_FIND: begin
          for (i = 0; i < ENTRIES; i++) begin
            cls = wide[i] ? CLASS_WIDE : CLASS_NARROW;
            if (live[i] && (cls & c.flags) != '0 &&
                lo_x[i] < $signed(c.x_hi) && hi_x[i] > $signed(c.x_lo) &&
                lo_y[i] < $signed(c.y_hi) && hi_y[i] > $signed(c.y_lo)) begin
              r.status = ST_OK;
              r.slot = SLOT_W'(i);
              break;
            end
          end
        end
        OP_READ: begin
          if (live[c.slot]) begin
            r.status = ST_OK;
            r.handle = hdl[c.slot];
            r.group  = grp[c.slot];
            r.sector = sec[c.slot];
          end
        end
        OP_CLEAR: begin
          foreach (live[k]) live[k] = 1'b0;
          r.status = ST_OK;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, field_name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      region_res_t got;
      region_res_t want;
      got = data[$bits(region_res_t)-1:0];
      if (pending.size() == 0) begin
        $display("%0t: result with no command outstanding: expected none actual %h",
                 $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("result_slot", 32'(want.slot), 32'(got.slot));
      compare_field("result_handle", want.handle, got.handle);
      compare_field("result_group", 32'(want.group), 32'(got.group));
      compare_field("result_sector", 32'(want.sector), 32'(got.sector));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  region_scoreboard sb;
  int sender_idle_pct;
  int stall_pct;
  int hold_left;
  int cycle_count;

  trigger_region_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left != 0) hold_left <= hold_left - 1;
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [IN_DATA_W-1:0] pack_cmd(region_cmd_t c);
    return IN_DATA_W'({c.handle, c.y_hi, c.x_hi, c.y_lo, c.x_lo, c.h_units, c.w_units,
                       c.flags, c.sector, c.group, c.slot});
  endfunction

  function automatic region_cmd_t rand_cmd(logic [OP_W-1:0] op);
    region_cmd_t c;
    bit          full_range;
    full_range = ($urandom_range(3) == 0);
    c.op       = op;
    c.slot     = SLOT_W'($urandom_range(ENTRIES - 1));
    c.group    = full_range ? GROUP_W'($urandom) : GROUP_W'($urandom_range(4) - 2);
    c.sector   = full_range ? SECTOR_W'($urandom) : SECTOR_W'($urandom_range(3) - 1);
    case ($urandom_range(3))
      0:       c.flags = '0;
      1:       c.flags = CLASS_NARROW;
      2:       c.flags = CLASS_WIDE & ~CLASS_NARROW;
      default: c.flags = FLAG_W'($urandom);
    endcase
    c.w_units  = UNITS_W'($urandom);
    c.h_units  = UNITS_W'($urandom);
    c.x_lo     = full_range ? LOW_W'($urandom) : LOW_W'($urandom_range(200000) - 100000);
    c.y_lo     = full_range ? LOW_W'($urandom) : LOW_W'($urandom_range(200000) - 100000);
    c.x_hi     = full_range ? HIGH_W'($urandom) :
                 HIGH_W'({c.x_lo[LOW_W-1], c.x_lo} + $urandom_range(300000) - 50000);
    c.y_hi     = full_range ? HIGH_W'($urandom) :
                 HIGH_W'({c.y_lo[LOW_W-1], c.y_lo} + $urandom_range(300000) - 50000);
    c.handle   = $urandom;
    return c;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 28) return OP_ADD_FREE;
    if (r < 38) return OP_ADD_AT;
    if (r < 48) return OP_CANCEL;
    if (r < 74) return OP_FIND;
    if (r < 90) return OP_READ;
    if (r < 94) return OP_CLEAR;
    return (r < 97) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  task automatic offer(input region_cmd_t c);
    in_tvalid <= 1'b1;
    in_tdata  <= pack_cmd(c);
    in_tuser  <= c.op;
    do @(posedge clk); while (!in_tready);
    sb.note_command(c);
  endtask

  task automatic idle_gap();
    int k;
    k = 0;
    while ($urandom_range(99) < sender_idle_pct) k++;
    if (k != 0) begin
      in_tvalid <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic run_directed();
    region_cmd_t c;
    // fill every slot once so that scans never touch unwritten entries, then overflow
    for (int i = 0; i <= ENTRIES; i++) offer(rand_cmd(OP_ADD_FREE));
    c = '0;
    c.op = OP_CLEAR;
    offer(c);
    c.op = OP_READ;
    offer(c);
    c.op   = OP_FIND;
    c.flags = '1;
    c.x_lo = {1'b1, {(LOW_W-1){1'b0}}};
    c.y_lo = {1'b1, {(LOW_W-1){1'b0}}};
    c.x_hi = {1'b0, {(HIGH_W-1){1'b1}}};
    c.y_hi = {1'b0, {(HIGH_W-1){1'b1}}};
    offer(c);
    c        = '0;
    c.op     = OP_ADD_FREE;
    c.group  = {1'b1, {(GROUP_W-1){1'b0}}};
    c.sector = {1'b1, {(SECTOR_W-1){1'b0}}};
    c.x_lo   = {1'b1, {(LOW_W-1){1'b0}}};
    c.y_lo   = {1'b1, {(LOW_W-1){1'b0}}};
    c.x_hi   = {1'b1, {(HIGH_W-1){1'b0}}};
    c.y_hi   = {1'b1, {(HIGH_W-1){1'b0}}};
    offer(c);
    c        = '1;
    c.op     = OP_ADD_FREE;
    c.group  = {1'b0, {(GROUP_W-1){1'b1}}};
    c.sector = {1'b0, {(SECTOR_W-1){1'b1}}};
    c.x_lo   = {1'b0, {(LOW_W-1){1'b1}}};
    c.y_lo   = {1'b0, {(LOW_W-1){1'b1}}};
    c.x_hi   = {1'b0, {(HIGH_W-1){1'b1}}};
    c.y_hi   = {1'b0, {(HIGH_W-1){1'b1}}};
    offer(c);
    c        = rand_cmd(OP_ADD_AT);
    c.slot   = SLOT_W'(ENTRIES - 1);
    c.group  = GROUP_W'(5);
    c.sector = SECTOR_W'(3);
    c.flags  = FLAG_W'(1);
    offer(c);
    c.slot   = '0;
    c.sector = SECTOR_W'(4);
    c.flags  = '0;
    offer(c);
    c    = '0;
    c.op = OP_READ;
    offer(c);
    c.slot = SLOT_W'(1);
    offer(c);
    c.slot = SLOT_W'(ENTRIES - 1);
    offer(c);
    c       = '0;
    c.op    = OP_FIND;
    c.x_lo  = {1'b1, {(LOW_W-1){1'b0}}};
    c.y_lo  = {1'b1, {(LOW_W-1){1'b0}}};
    c.x_hi  = {1'b0, {(HIGH_W-1){1'b1}}};
    c.y_hi  = {1'b0, {(HIGH_W-1){1'b1}}};
    c.flags = CLASS_WIDE & ~CLASS_NARROW;
    offer(c);
    c.flags = CLASS_NARROW;
    offer(c);
    c.flags = ~CLASS_WIDE;
    offer(c);
    c        = '0;
    c.op     = OP_CANCEL;
    c.group  = GROUP_W'(5);
    c.sector = SECTOR_W'(3);
    offer(c);
    c.op   = OP_READ;
    c.slot = SLOT_W'(ENTRIES - 1);
    offer(c);
    c.op     = OP_CANCEL;
    c.sector = '1;
    offer(c);
    c.group = GROUP_W'(1234);
    offer(c);
    c    = '0;
    c.op = OP_SPARE_6;
    offer(c);
    c.op = OP_SPARE_7;
    offer(c);
    c.op   = OP_READ;
    c.slot = SLOT_W'(1);
    offer(c);
  endtask

  initial begin
    int ph;
    int n;
    sb              = new();
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    out_tready      = 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_left       = 0;
    cycle_count     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          sender_idle_pct = 14;
          stall_pct <= 14;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 40) hold_left <= HOLD_CYCLES;
        if (n == 100) drain();
        // fill the table to full in a burst once per phase
        offer(rand_cmd((n >= 60 && n < 96) ? OP_ADD_FREE : pick_op()));
        idle_gap();
      end
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/trt_pkg.sv
hw/rtl/trt_datapath.sv
hw/rtl/trt_ctrl.sv
hw/rtl/trigger_region_table.sv
verif/tb_trigger_region_table.sv
